// ===== src/annexb_pkg.sv =====
// ----------------------------------------------------------------------------
// annexb_pkg
// Shared types and constants of the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package annexb_pkg;

  // Stream position width (16..48)
  localparam int unsigned POS_BITS = 32;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [63:0]         LEN_MAX = 64'h0000_0000_FFFF_FFFF;

  localparam logic [23:0] RECENT_RESET = 24'hFF_FFFF;
  localparam logic [7:0]  CODE_BYTE    = 8'h01;

  localparam logic [2:0] SC_LEN_3 = 3'd3;
  localparam logic [2:0] SC_LEN_4 = 3'd4;

  localparam logic [5:0] H265_TYPE_MAX = 6'd47;
  localparam logic [4:0] H264_TYPE_END = 5'd22;
  localparam logic [4:0] H264_TYPE_MIN = 5'd1;
  localparam logic [2:0] H265_TID_BASE = 3'd1;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    CODEC_H264 = 1'b0,
    CODEC_H265 = 1'b1
  } codec_e;

  // Raw record handed from the scanner to the formatter
  typedef struct packed {
    logic [31:0]         index;
    logic [POS_BITS-1:0] offset;
    logic [POS_BITS-1:0] end_pos;
    logic [2:0]          sc_len;
    logic [15:0]         header;
    logic                is_final;
  } rec_t;

endpackage

`default_nettype wire

// ===== src/annexb_ifs.sv =====
// ----------------------------------------------------------------------------
// annexb_ifs
// Handshake channels of the splitter: byte input, NAL records, config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface annexb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface annexb_rec_if;
  logic        valid;
  logic        ready;
  logic [31:0] nal_index;
  logic [31:0] nal_offset;
  logic [31:0] nal_length;
  logic [2:0]  start_code_len;
  logic [5:0]  nal_type;
  logic [5:0]  layer_id;
  logic [2:0]  temporal_id_plus1;
  logic        header_valid;
  logic        is_final;

  modport source (output valid, output nal_index, output nal_offset, output nal_length,
                  output start_code_len, output nal_type, output layer_id,
                  output temporal_id_plus1, output header_valid, output is_final,
                  input ready);
  modport sink   (input valid, input nal_index, input nal_offset, input nal_length,
                  input start_code_len, input nal_type, input layer_id,
                  input temporal_id_plus1, input header_valid, input is_final,
                  output ready);
endinterface

interface annexb_cfg_if;
  logic valid;
  logic ready;
  logic codec_mode;

  modport source (output valid, output codec_mode, input ready);
  modport sink   (input valid, input codec_mode, output ready);
endinterface

`default_nettype wire

// ===== src/annexb_front.sv =====
// ----------------------------------------------------------------------------
// annexb_front
// Byte scanner: start code detection, position tracking, header capture.
// Pushes one raw record per closed NAL unit.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            end_of_stream_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output annexb_pkg::rec_t     rec_o
);
  import annexb_pkg::*;

  logic [23:0]         recent_q, recent_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic                open_q, open_d;
  logic [POS_BITS-1:0] off_q, off_d;
  logic [2:0]          sc_q, sc_d;
  logic [15:0]         hdr_q, hdr_d;
  logic [1:0]          bsc_q, bsc_d;
  logic [31:0]         cnt_q, cnt_d;

  logic                accept;
  logic                code;
  logic                sc4;
  logic [POS_BITS-1:0] sc_back;
  logic [POS_BITS-1:0] start;
  logic                take_hdr;
  logic [15:0]         hdr_upd;
  logic                emit_code, emit_eos;
  logic [POS_BITS-1:0] eos_end;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    code    = (data_byte_i == CODE_BYTE) && (recent_q[15:0] == 16'h0000);
    sc4     = (recent_q[23:16] == 8'h00);
    // start code begins sc_len - 1 bytes back, clamped at zero
    sc_back = sc4 ? POS_BITS'(3) : POS_BITS'(2);
    start   = (pos_q >= sc_back) ? (pos_q - sc_back) : '0;

    take_hdr = !code && open_q && (bsc_q < 2'd2);
    hdr_upd  = hdr_q;
    if (take_hdr) begin
      if (bsc_q == 2'd0) begin
        hdr_upd = hdr_q | {data_byte_i, 8'h00};
      end else begin
        hdr_upd = hdr_q | {8'h00, data_byte_i};
      end
    end

    emit_code = code && open_q;
    emit_eos  = end_of_stream_i && !code && open_q;
    eos_end   = (pos_q != POS_MAX) ? (pos_q + POS_BITS'(1)) : pos_q;

    rec_o.index    = cnt_q;
    rec_o.offset   = off_q;
    rec_o.end_pos  = emit_code ? start : eos_end;
    rec_o.sc_len   = sc_q;
    rec_o.header   = emit_code ? hdr_q : hdr_upd;
    rec_o.is_final = end_of_stream_i;
    push_o         = accept && (emit_code || emit_eos);
  end

  always_comb begin
    recent_d = recent_q;
    pos_d    = pos_q;
    open_d   = open_q;
    off_d    = off_q;
    sc_d     = sc_q;
    hdr_d    = hdr_q;
    bsc_d    = bsc_q;
    cnt_d    = cnt_q;
    if (accept) begin
      if (end_of_stream_i) begin
        recent_d = RECENT_RESET;
        pos_d    = '0;
        open_d   = 1'b0;
        off_d    = '0;
        sc_d     = SC_LEN_3;
        hdr_d    = '0;
        bsc_d    = '0;
        cnt_d    = '0;
      end else begin
        recent_d = {recent_q[15:0], data_byte_i};
        if (pos_q != POS_MAX) begin
          pos_d = pos_q + POS_BITS'(1);
        end
        if (emit_code) begin
          cnt_d = cnt_q + 32'd1;
        end
        if (code) begin
          open_d = 1'b1;
          off_d  = start;
          sc_d   = sc4 ? SC_LEN_4 : SC_LEN_3;
          hdr_d  = '0;
          bsc_d  = '0;
        end else if (take_hdr) begin
          hdr_d = hdr_upd;
          bsc_d = bsc_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= RECENT_RESET;
      pos_q    <= '0;
      open_q   <= 1'b0;
      off_q    <= '0;
      sc_q     <= SC_LEN_3;
      hdr_q    <= '0;
      bsc_q    <= '0;
      cnt_q    <= '0;
    end else begin
      recent_q <= recent_d;
      pos_q    <= pos_d;
      open_q   <= open_d;
      off_q    <= off_d;
      sc_q     <= sc_d;
      hdr_q    <= hdr_d;
      bsc_q    <= bsc_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/annexb_fifo.sv =====
// ----------------------------------------------------------------------------
// annexb_fifo
// Short record queue between scanner and formatter.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire annexb_pkg::rec_t wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output annexb_pkg::rec_t      rdata_o
);
  import annexb_pkg::*;

  rec_t mem_q [FIFO_DEPTH];

  logic [FIFO_PTR_W-1:0] wr_q, wr_d;
  logic [FIFO_PTR_W-1:0] rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    logic [FIFO_PTR_W-1:0] r;
    if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + FIFO_PTR_W'(1);
    end
    return r;
  endfunction

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = (push_i) ? ptr_inc(wr_q) : wr_q;
    rd_d  = (pop_i) ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + FIFO_CNT_W'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/annexb_back.sv =====
// ----------------------------------------------------------------------------
// annexb_back
// Record formatter: length with saturation, header decode per codec,
// output register toward the record channel.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire annexb_pkg::codec_e codec_i,
  input  wire logic               empty_i,
  input  wire annexb_pkg::rec_t   rec_i,
  output logic                    pop_o,
  annexb_rec_if.source            rec_o
);
  import annexb_pkg::*;

  logic        valid_q, valid_d;
  logic [31:0] index_q, offset_q, length_q;
  logic [2:0]  sc_q;
  logic [5:0]  type_q, layer_q;
  logic [2:0]  tid_q;
  logic        hvalid_q, final_q;

  logic [POS_BITS-1:0] len_raw;
  logic [31:0]         len_sat;
  logic [7:0]          h0, h1;
  logic [5:0]          typ, layer;
  logic [2:0]          tid;
  logic                hvalid;

  always_comb begin
    len_raw = (rec_i.end_pos >= rec_i.offset) ? (rec_i.end_pos - rec_i.offset) : '0;
    if ({1'b0, len_raw} > (POS_BITS + 1)'(LEN_MAX)) begin
      len_sat = 32'hFFFF_FFFF;
    end else begin
      len_sat = 32'(len_raw);
    end

    h0 = rec_i.header[15:8];
    h1 = rec_i.header[7:0];
    case (codec_i)
      CODEC_H265: begin
        typ    = h0[6:1];
        layer  = {h0[0], h1[7:3]};
        tid    = h1[2:0];
        hvalid = (typ <= H265_TYPE_MAX) && (layer == 6'd0) && (tid == H265_TID_BASE);
      end
      default: begin
        typ    = {1'b0, h0[4:0]};
        layer  = '0;
        tid    = '0;
        hvalid = (h0[4:0] >= H264_TYPE_MIN) && (h0[4:0] < H264_TYPE_END);
      end
    endcase

    pop_o   = !empty_i && (!valid_q || rec_o.ready);
    valid_d = pop_o ? 1'b1 : (valid_q && !rec_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      index_q  <= rec_i.index;
      offset_q <= 32'(rec_i.offset);
      length_q <= len_sat;
      sc_q     <= rec_i.sc_len;
      type_q   <= typ;
      layer_q  <= layer;
      tid_q    <= tid;
      hvalid_q <= hvalid;
      final_q  <= rec_i.is_final;
    end
  end

  assign rec_o.valid             = valid_q;
  assign rec_o.nal_index         = index_q;
  assign rec_o.nal_offset        = offset_q;
  assign rec_o.nal_length        = length_q;
  assign rec_o.start_code_len    = sc_q;
  assign rec_o.nal_type          = type_q;
  assign rec_o.layer_id          = layer_q;
  assign rec_o.temporal_id_plus1 = tid_q;
  assign rec_o.header_valid      = hvalid_q;
  assign rec_o.is_final          = final_q;

endmodule

`default_nettype wire

// ===== src/annexb_nal_unit_splitter.sv =====
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits an Annex B byte stream into NAL unit records.
//
// byte_i takes one stream byte per beat; end_of_stream on a beat closes
// the open unit (record marked final) and restarts position and index
// counting at zero. rec_o gives one record per finished NAL unit: index,
// offset of its start code, length up to the next start code (saturating),
// start code length and the decoded header. cfg_i writes codec_mode
// (0 H.264, 1 H.265); write it only while no records are in flight.
// Throughput: one byte per cycle while the two-entry record queue
// between scanner and formatter is not full. A closed record passes
// through the queue and the formatter's output register to rec_o.
// When rec_o stalls, the queue fills and byte_i.ready drops while the
// queue is full. Reset clears scanner state, the queue and codec_mode;
// no clearing pass is needed, the block is ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_nal_unit_splitter (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  annexb_cfg_if.sink   cfg_i,
  annexb_byte_if.sink  byte_i,
  annexb_rec_if.source rec_o
);
  import annexb_pkg::*;

  codec_e codec_q, codec_d;

  logic full, empty, push, pop;
  rec_t front_rec, queue_rec;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    codec_d = codec_q;
    if (cfg_i.valid && cfg_i.ready) begin
      codec_d = codec_e'(cfg_i.codec_mode);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_q <= CODEC_H264;
    end else begin
      codec_q <= codec_d;
    end
  end

  annexb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (byte_i.valid),
    .in_ready_o      (byte_i.ready),
    .data_byte_i     (byte_i.data_byte),
    .end_of_stream_i (byte_i.end_of_stream),
    .full_i          (full),
    .push_o          (push),
    .rec_o           (front_rec)
  );

  annexb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_rec),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (queue_rec)
  );

  annexb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .codec_i (codec_q),
    .empty_i (empty),
    .rec_i   (queue_rec),
    .pop_o   (pop),
    .rec_o   (rec_o)
  );

endmodule

`default_nettype wire
